// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NNFD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NNFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/nnfd_pkg.sv -----
// Shared types and constants of the nearest-neighbor fit downscaler.
`default_nettype none

package nnfd_pkg;

    localparam int unsigned MAX_DIM   = 8192;
    localparam int unsigned DIM_W     = 14;   // frame sizes, 2..MAX_DIM
    localparam int unsigned POS_W     = 13;   // source pixel positions
    localparam int unsigned STRIDE_W  = 16;
    localparam int unsigned PIX_W     = 32;
    localparam int unsigned PROD_W    = 2 * DIM_W - 1;
    localparam int unsigned DIV_DVD_W = PROD_W + 1;
    localparam int unsigned DIV_DVS_W = DIM_W + 1;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_DVD_W);
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [DIM_W-1:0]    RST_SRC_WIDTH    = DIM_W'(1920);
    localparam logic [DIM_W-1:0]    RST_SRC_HEIGHT   = DIM_W'(1080);
    localparam logic [STRIDE_W-1:0] RST_SRC_STRIDE   = '0;
    localparam logic [DIM_W-1:0]    RST_LIMIT_WIDTH  = DIM_W'(1920);
    localparam logic [DIM_W-1:0]    RST_LIMIT_HEIGHT = DIM_W'(1080);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH    = 3'd0,
        CFG_SRC_HEIGHT   = 3'd1,
        CFG_SRC_STRIDE   = 3'd2,
        CFG_LIMIT_WIDTH  = 3'd3,
        CFG_LIMIT_HEIGHT = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_SIZE = 2'd0,
        DIV_COL  = 2'd1,
        DIV_ROW  = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul;
        logic     div_start;
        div_sel_t div_sel;
        logic     size_take;
        logic     col_take;
        logic     row_take;
        logic     pix_take;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic src_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/nearest_neighbor_fit_downscale.sv -----
// Top level of the nearest-neighbor fit-to-limits downscaler.
//
// Source BGRA pixels enter on s_* in row-major order, one item per pixel.
// Selected pixels leave on m_* with their output column, row, frame size
// and row/frame end flags. A frame that fits the limits with a packed
// stride passes through unchanged; otherwise it is fitted and decimated.
// Registers are written on cfg_*: index 0 src width, 1 src height,
// 2 stride in bytes, 3 limit width, 4 limit height. They are sampled
// when the first pixel of each frame is offered.
// Throughput: one pixel per cycle inside a frame while the output is not
// stalled. Before the first pixel of each frame the block holds s_ready
// low from the cycle s_valid is first seen, through a load, a multiply
// and three passes of the shared 28-step divider (output size, then
// column and row step sizes), each pass opened by its own start.
// A selected pixel is registered on m_* in the cycle after it is accepted.
// A stalled m_ready holds the output register; s_ready drops while it is
// full and not being taken, so no item is lost.
// Reset (aresetn low, synchronous) restores the register defaults, empties
// the output and starts a new frame at the next pixel.
`default_nettype none

module nearest_neighbor_fit_downscale (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [nnfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nnfd_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [nnfd_pkg::PIX_W-1:0]      s_pixel_in,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [nnfd_pkg::PIX_W-1:0]      m_pixel_out,
    output logic      [nnfd_pkg::POS_W-1:0]      m_out_col,
    output logic      [nnfd_pkg::POS_W-1:0]      m_out_row,
    output logic      [nnfd_pkg::DIM_W-1:0]      m_out_width,
    output logic      [nnfd_pkg::DIM_W-1:0]      m_out_height,
    output logic                                 m_row_end,
    output logic                                 m_frame_end
);

    nnfd_pkg::ctrl_cmd_t  cmd;
    nnfd_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    nnfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    nnfd_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .s_pixel_in   (s_pixel_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_out_col    (m_out_col),
        .m_out_row    (m_out_row),
        .m_out_width  (m_out_width),
        .m_out_height (m_out_height),
        .m_row_end    (m_row_end),
        .m_frame_end  (m_frame_end)
    );

endmodule

`default_nettype wire

// ----- src/nnfd_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module nnfd_div (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [nnfd_pkg::DIV_DVD_W-1:0] dividend,
    input  wire logic [nnfd_pkg::DIV_DVS_W-1:0] divisor,
    output logic      [nnfd_pkg::DIV_DVD_W-1:0] quotient,
    output logic      [nnfd_pkg::DIV_DVS_W-1:0] remainder,
    output logic                                done
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [nnfd_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [nnfd_pkg::DIV_DVD_W-1:0] dvd_reg, dvd_next;
    logic [nnfd_pkg::DIV_DVS_W-1:0] dvs_reg, dvs_next;
    logic [nnfd_pkg::DIV_DVS_W-1:0] rem_reg, rem_next;

    logic [nnfd_pkg::DIV_DVS_W:0]   shifted;
    logic [nnfd_pkg::DIV_DVS_W:0]   diff;
    logic                           ge;

    assign shifted = {rem_reg, dvd_reg[nnfd_pkg::DIV_DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[nnfd_pkg::DIV_DVD_W-2:0], ge};
            rem_next = ge ? diff[nnfd_pkg::DIV_DVS_W-1:0] : shifted[nnfd_pkg::DIV_DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == nnfd_pkg::DIV_CNT_W'(nnfd_pkg::DIV_DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign quotient  = dvd_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

// ----- src/nnfd_ctrl.sv -----
// Controller: frame setup sequence and input handshake.
`default_nettype none

module nnfd_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire nnfd_pkg::dp_status_t status,
    output nnfd_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [8:0] {
        ST_RUN      = 9'b000000001,
        ST_LOAD     = 9'b000000010,
        ST_MUL      = 9'b000000100,
        ST_SZ_GO    = 9'b000001000,
        ST_SZ_WAIT  = 9'b000010000,
        ST_COL_GO   = 9'b000100000,
        ST_COL_WAIT = 9'b001000000,
        ST_ROW_GO   = 9'b010000000,
        ST_ROW_WAIT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   need_setup_reg, need_setup_next;

    assign s_ready = (state_reg == ST_RUN) && !need_setup_reg && status.out_free;

    always_comb begin
        state_next      = state_reg;
        need_setup_next = need_setup_reg;
        cmd             = '0;
        cmd.pix_take    = s_valid && s_ready;
        unique case (state_reg)
            ST_RUN: begin
                if (need_setup_reg && s_valid) begin
                    state_next = ST_LOAD;
                end
                // after the last source pixel the next item opens a new frame
                if (cmd.pix_take && status.src_last) begin
                    need_setup_next = 1'b1;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SZ_GO;
            end
            ST_SZ_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = nnfd_pkg::DIV_SIZE;
                state_next    = ST_SZ_WAIT;
            end
            ST_SZ_WAIT: begin
                cmd.div_sel = nnfd_pkg::DIV_SIZE;
                if (status.div_done) begin
                    cmd.size_take = 1'b1;
                    state_next    = ST_COL_GO;
                end
            end
            ST_COL_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = nnfd_pkg::DIV_COL;
                state_next    = ST_COL_WAIT;
            end
            ST_COL_WAIT: begin
                cmd.div_sel = nnfd_pkg::DIV_COL;
                if (status.div_done) begin
                    cmd.col_take = 1'b1;
                    state_next   = ST_ROW_GO;
                end
            end
            ST_ROW_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = nnfd_pkg::DIV_ROW;
                state_next    = ST_ROW_WAIT;
            end
            ST_ROW_WAIT: begin
                cmd.div_sel = nnfd_pkg::DIV_ROW;
                if (status.div_done) begin
                    cmd.row_take    = 1'b1;
                    need_setup_next = 1'b0;
                    state_next      = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            need_setup_reg <= 1'b1;
        end else begin
            state_reg      <= state_next;
            need_setup_reg <= need_setup_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/nnfd_dp.sv -----
// Datapath: config registers, frame size setup, pixel selection, output register.
`default_nettype none

module nnfd_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    input  wire logic [nnfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nnfd_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  wire nnfd_pkg::ctrl_cmd_t             cmd,
    output nnfd_pkg::dp_status_t                 status,
    input  wire logic [nnfd_pkg::PIX_W-1:0]      s_pixel_in,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [nnfd_pkg::PIX_W-1:0]      m_pixel_out,
    output logic      [nnfd_pkg::POS_W-1:0]      m_out_col,
    output logic      [nnfd_pkg::POS_W-1:0]      m_out_row,
    output logic      [nnfd_pkg::DIM_W-1:0]      m_out_width,
    output logic      [nnfd_pkg::DIM_W-1:0]      m_out_height,
    output logic                                 m_row_end,
    output logic                                 m_frame_end
);

    localparam int unsigned DW = nnfd_pkg::DIM_W;
    localparam int unsigned PW = nnfd_pkg::POS_W;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
        logic [DW-1:0] r;
        r = v;
        if (v < DW'(2)) begin
            r = DW'(2);
        end else if (v > DW'(nnfd_pkg::MAX_DIM)) begin
            r = DW'(nnfd_pkg::MAX_DIM);
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] fix_even(input logic [DW-1:0] v);
        logic [DW-1:0] r;
        r = {v[DW-1:1], 1'b0};
        if (v < DW'(2)) begin
            r = DW'(2);
        end
        return r;
    endfunction

    // configuration registers
    logic [DW-1:0]                  src_width_reg, src_height_reg;
    logic [DW-1:0]                  limit_width_reg, limit_height_reg;
    logic [nnfd_pkg::STRIDE_W-1:0]  stride_reg;

    // frame setup
    logic [DW-1:0]                  w_reg, h_reg, lw_reg, lh_reg;
    logic                           packed_reg;
    logic [nnfd_pkg::PROD_W-1:0]    prod_a_reg, prod_b_reg;
    logic                           pass_reg;
    logic [DW-1:0]                  dst_w_reg, dst_h_reg;
    logic [DW-1:0]                  qw_reg, rw_reg, qh_reg, rh_reg;

    // pixel walk
    logic [PW-1:0]                  in_col_reg, in_row_reg;
    logic [DW-1:0]                  dst_col_reg, dst_row_reg;
    logic [DW-1:0]                  want_col_reg, want_row_reg;
    logic [DW-1:0]                  col_rem_reg, row_rem_reg;

    logic                           m_valid_reg;

    // divider hookup
    logic [nnfd_pkg::DIV_DVD_W-1:0] div_dvd;
    logic [nnfd_pkg::DIV_DVS_W-1:0] div_dvs;
    logic [nnfd_pkg::DIV_DVD_W-1:0] div_quo;
    logic [nnfd_pkg::DIV_DVS_W-1:0] div_rem;
    logic                           div_done;

    logic                           fits;
    logic                           bound_w;
    logic [DW-1:0]                  size_q;
    logic [DW-1:0]                  dw_raw, dh_raw;

    logic                           last_col, last_row;
    logic                           row_hit, col_hit, emit;
    logic [DW:0]                    col_sum, row_sum;
    logic                           col_wrap, row_wrap;
    logic [DW-1:0]                  dst_col_inc, dst_row_inc;

    assign fits    = (w_reg <= lw_reg) && (h_reg <= lh_reg);
    assign bound_w = prod_a_reg <= prod_b_reg;

    always_comb begin
        case (cmd.div_sel)
            nnfd_pkg::DIV_SIZE: begin
                if (bound_w) begin
                    div_dvd = {prod_a_reg, 1'b0} + nnfd_pkg::DIV_DVD_W'(w_reg);
                    div_dvs = {w_reg, 1'b0};
                end else begin
                    div_dvd = {prod_b_reg, 1'b0} + nnfd_pkg::DIV_DVD_W'(h_reg);
                    div_dvs = {h_reg, 1'b0};
                end
            end
            nnfd_pkg::DIV_COL: begin
                div_dvd = nnfd_pkg::DIV_DVD_W'(w_reg);
                div_dvs = nnfd_pkg::DIV_DVS_W'(dst_w_reg);
            end
            nnfd_pkg::DIV_ROW: begin
                div_dvd = nnfd_pkg::DIV_DVD_W'(h_reg);
                div_dvs = nnfd_pkg::DIV_DVS_W'(dst_h_reg);
            end
            default: begin
                div_dvd = '0;
                div_dvs = '0;
            end
        endcase
    end

    nnfd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    assign size_q = div_quo[DW-1:0];

    always_comb begin
        if (fits) begin
            dw_raw = w_reg;
            dh_raw = h_reg;
        end else if (bound_w) begin
            dw_raw = lw_reg;
            dh_raw = size_q;
        end else begin
            dw_raw = size_q;
            dh_raw = lh_reg;
        end
    end

    // per-pixel selection
    assign last_col = ({1'b0, in_col_reg} + DW'(1)) >= w_reg;
    assign last_row = ({1'b0, in_row_reg} + DW'(1)) >= h_reg;
    assign row_hit  = ({1'b0, in_row_reg} == want_row_reg) && (dst_row_reg < dst_h_reg);
    assign col_hit  = ({1'b0, in_col_reg} == want_col_reg) && (dst_col_reg < dst_w_reg);
    assign emit     = pass_reg || (row_hit && col_hit);

    assign dst_col_inc = dst_col_reg + DW'(1);
    assign dst_row_inc = dst_row_reg + DW'(1);

    // want advances by the whole step plus one when the remainder wraps
    assign col_sum  = {1'b0, col_rem_reg} + {1'b0, rw_reg};
    assign col_wrap = col_sum >= {1'b0, dst_w_reg};
    assign row_sum  = {1'b0, row_rem_reg} + {1'b0, rh_reg};
    assign row_wrap = row_sum >= {1'b0, dst_h_reg};

    assign status.div_done = div_done;
    assign status.src_last = last_col && last_row;
    assign status.out_free = !m_valid_reg || m_ready;

    // config writes and setup results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg    <= nnfd_pkg::RST_SRC_WIDTH;
            src_height_reg   <= nnfd_pkg::RST_SRC_HEIGHT;
            stride_reg       <= nnfd_pkg::RST_SRC_STRIDE;
            limit_width_reg  <= nnfd_pkg::RST_LIMIT_WIDTH;
            limit_height_reg <= nnfd_pkg::RST_LIMIT_HEIGHT;
            pass_reg         <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (nnfd_pkg::cfg_idx_t'(cfg_index))
                    nnfd_pkg::CFG_SRC_WIDTH:    src_width_reg    <= cfg_data[DW-1:0];
                    nnfd_pkg::CFG_SRC_HEIGHT:   src_height_reg   <= cfg_data[DW-1:0];
                    nnfd_pkg::CFG_SRC_STRIDE:   stride_reg       <= cfg_data;
                    nnfd_pkg::CFG_LIMIT_WIDTH:  limit_width_reg  <= cfg_data[DW-1:0];
                    nnfd_pkg::CFG_LIMIT_HEIGHT: limit_height_reg <= cfg_data[DW-1:0];
                    default: ;
                endcase
            end
            if (cmd.size_take) begin
                pass_reg <= fits && packed_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            w_reg      <= clamp_dim(src_width_reg);
            h_reg      <= clamp_dim(src_height_reg);
            lw_reg     <= clamp_dim(limit_width_reg);
            lh_reg     <= clamp_dim(limit_height_reg);
            packed_reg <= (stride_reg == '0) ||
                          (stride_reg == {clamp_dim(src_width_reg), 2'b00});
        end
        if (cmd.mul) begin
            prod_a_reg <= nnfd_pkg::PROD_W'(lw_reg) * nnfd_pkg::PROD_W'(h_reg);
            prod_b_reg <= nnfd_pkg::PROD_W'(lh_reg) * nnfd_pkg::PROD_W'(w_reg);
        end
        if (cmd.size_take) begin
            if (fits && packed_reg) begin
                dst_w_reg <= w_reg;
                dst_h_reg <= h_reg;
            end else begin
                dst_w_reg <= fix_even(dw_raw);
                dst_h_reg <= fix_even(dh_raw);
            end
        end
        if (cmd.col_take) begin
            qw_reg <= div_quo[DW-1:0];
            rw_reg <= div_rem[DW-1:0];
        end
        if (cmd.row_take) begin
            qh_reg <= div_quo[DW-1:0];
            rh_reg <= div_rem[DW-1:0];
        end
    end

    // source walk and output position tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            dst_col_reg  <= '0;
            dst_row_reg  <= '0;
            want_col_reg <= '0;
            want_row_reg <= '0;
            col_rem_reg  <= '0;
            row_rem_reg  <= '0;
        end else if (cmd.row_take) begin
            dst_col_reg  <= '0;
            dst_row_reg  <= '0;
            want_col_reg <= '0;
            want_row_reg <= '0;
            col_rem_reg  <= '0;
            row_rem_reg  <= '0;
        end else if (cmd.pix_take) begin
            if (!pass_reg && col_hit) begin
                dst_col_reg  <= dst_col_inc;
                want_col_reg <= want_col_reg + qw_reg + DW'(col_wrap);
                col_rem_reg  <= col_wrap ? DW'(col_sum - {1'b0, dst_w_reg}) : col_sum[DW-1:0];
            end
            if (!pass_reg && last_col && row_hit) begin
                dst_row_reg  <= dst_row_inc;
                want_row_reg <= want_row_reg + qh_reg + DW'(row_wrap);
                row_rem_reg  <= row_wrap ? DW'(row_sum - {1'b0, dst_h_reg}) : row_sum[DW-1:0];
            end
            if (last_col) begin
                in_col_reg   <= '0;
                dst_col_reg  <= '0;
                want_col_reg <= '0;
                col_rem_reg  <= '0;
                in_row_reg   <= last_row ? '0 : in_row_reg + PW'(1);
            end else begin
                in_col_reg   <= in_col_reg + PW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.pix_take && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pix_take && emit) begin
            m_pixel_out  <= s_pixel_in;
            m_out_width  <= dst_w_reg;
            m_out_height <= dst_h_reg;
            if (pass_reg) begin
                m_out_col   <= in_col_reg;
                m_out_row   <= in_row_reg;
                m_row_end   <= last_col;
                m_frame_end <= last_col && last_row;
            end else begin
                m_out_col   <= dst_col_reg[PW-1:0];
                m_out_row   <= dst_row_reg[PW-1:0];
                m_row_end   <= dst_col_inc == dst_w_reg;
                m_frame_end <= (dst_col_inc == dst_w_reg) && (dst_row_inc == dst_h_reg);
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- src/nnfd_port_check.sv -----
// Port-level checker for the downscaler, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module nnfd_port_check (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [nnfd_pkg::PIX_W-1:0]      m_pixel_out,
    input wire logic [nnfd_pkg::POS_W-1:0]      m_out_col,
    input wire logic [nnfd_pkg::DIM_W-1:0]      m_out_width,
    input wire logic [nnfd_pkg::DIM_W-1:0]      m_out_height,
    input wire logic                            m_row_end,
    input wire logic                            m_frame_end
);

    `NNFD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pixel_out), "output item changed while stalled")

    `NNFD_ASSERT_IMPL(a_size_min, aclk, aresetn, m_valid, (m_out_width >= nnfd_pkg::DIM_W'(2)) && (m_out_height >= nnfd_pkg::DIM_W'(2)), "output frame smaller than 2x2")

    `NNFD_ASSERT_IMPL(a_frame_row, aclk, aresetn, m_valid && m_frame_end, m_row_end, "frame end without row end")

    `NNFD_ASSERT_IMPL(a_row_end_col, aclk, aresetn, m_valid && m_row_end, (nnfd_pkg::DIM_W'(m_out_col) + nnfd_pkg::DIM_W'(1)) == m_out_width, "row end not on last column")

endmodule

bind nearest_neighbor_fit_downscale nnfd_port_check u_port_check (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_pixel_out  (m_pixel_out),
    .m_out_col    (m_out_col),
    .m_out_width  (m_out_width),
    .m_out_height (m_out_height),
    .m_row_end    (m_row_end),
    .m_frame_end  (m_frame_end)
);

`default_nettype wire
